// ----- src/particle_sensor_frame_parser_top_defines.svh -----
// Assertion macros shared by the frame parser RTL
`ifndef PARTICLE_SENSOR_FRAME_PARSER_TOP_DEFINES_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, sampled on clk, quiet during reset
`define PSFP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define PSFP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PSFP_ASSERT_IMP(label, ante, cons, msg)
`define PSFP_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ----- src/psfp_pkg.sv -----
// Package: types, sizes and register codes of the particle sensor frame parser
`timescale 1ns / 1ps

package psfp_pkg;

    // frame geometry
    localparam int FRAME_LENGTH = 32;
    localparam int POS_W        = $clog2(FRAME_LENGTH);
    localparam int OFF_W        = 5;
    localparam int CMP_W        = ((POS_W > OFF_W) ? POS_W : OFF_W) + 1;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_START  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SECOND_START = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PM1_OFF      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PM25_OFF     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PM10_OFF     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CSUM_OFF     = 3'd5;

    localparam logic [7:0]       RST_FIRST_START  = 8'd66;
    localparam logic [7:0]       RST_SECOND_START = 8'd77;
    localparam logic [OFF_W-1:0] RST_PM1_OFF      = 5'd4;
    localparam logic [OFF_W-1:0] RST_PM25_OFF     = 5'd6;
    localparam logic [OFF_W-1:0] RST_PM10_OFF     = 5'd8;
    localparam logic [OFF_W-1:0] RST_CSUM_OFF     = 5'd30;

    typedef struct packed {
        logic [OFF_W-1:0] pm1;
        logic [OFF_W-1:0] pm25;
        logic [OFF_W-1:0] pm10;
        logic [OFF_W-1:0] csum;
    } psfp_offs_t;

    // controls fanned out to every cell of the row
    typedef struct packed {
        logic cap_shift;
        logic eval_load;
        logic eval_shift;
    } psfp_cell_ctrl_t;

    typedef struct packed {
        logic [15:0] pm1;
        logic [15:0] pm25;
        logic [15:0] pm10;
        logic [15:0] csum;
        logic [15:0] rsum;
    } psfp_acc_t;

    typedef struct packed {
        psfp_acc_t acc;
        logic      ok;
    } psfp_result_t;

    // place a byte into a big-endian pair when the scan reaches its high or low slot
    function automatic logic [15:0] pair_upd(
        input logic [15:0]      acc,
        input logic [OFF_W-1:0] off,
        input logic [POS_W-1:0] pos,
        input logic [7:0]       b
    );
        logic [CMP_W-1:0] p;
        logic [CMP_W-1:0] hi;
        logic [CMP_W-1:0] lo;
        p  = CMP_W'(pos);
        hi = CMP_W'(off);
        lo = CMP_W'(off) + CMP_W'(1);
        if (p == hi) begin
            return {b, acc[7:0]};
        end
        else if (p == lo) begin
            return {acc[15:8], b};
        end
        return acc;
    endfunction

endpackage

// ----- src/psfp_cell.sv -----
// One cell of the byte row: capture stage plus scan stage
`timescale 1ns / 1ps

module psfp_cell
    import psfp_pkg::*;
(
    input  logic            clk,
    input  psfp_cell_ctrl_t ctrl,
    input  logic [7:0]      cap_in,
    input  logic [7:0]      eval_in,
    output logic [7:0]      cap_q,
    output logic [7:0]      eval_q
);

    logic [7:0] cap_reg;
    logic [7:0] eval_reg;

    // shift received bytes along the capture stage
    always_ff @(posedge clk)
    begin
        if (ctrl.cap_shift)
        begin
            cap_reg <= cap_in;
        end
    end

    // take a snapshot of the row as the closing byte shifts in, then pass it towards
    // the tally one byte a cycle while eval_shift is set
    always_ff @(posedge clk)
    begin
        if (ctrl.eval_load)
        begin
            eval_reg <= cap_in;
        end
        else if (ctrl.eval_shift)
        begin
            eval_reg <= eval_in;
        end
    end

    assign cap_q  = cap_reg;
    assign eval_q = eval_reg;

endmodule

// ----- src/psfp_tally.sv -----
// Tally at the end of the cell row: picks readings and sums bytes as they stream out
`timescale 1ns / 1ps

module psfp_tally
    import psfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         step,
    input  psfp_offs_t   offs,
    input  logic [7:0]   byte_in,
    output logic         busy,
    output logic         last,
    output psfp_result_t res
);

    logic             busy_reg;
    logic             busy_next;
    logic [POS_W-1:0] cnt_reg;
    logic [POS_W-1:0] cnt_next;
    psfp_offs_t       offs_reg;
    psfp_acc_t        acc_reg;
    psfp_acc_t        acc_next;

    assign last = busy_reg && (cnt_reg == POS_W'(FRAME_LENGTH - 1));
    assign busy = busy_reg;

    // fold the byte at position cnt into the running results
    always_comb
    begin
        acc_next      = acc_reg;
        acc_next.pm1  = pair_upd(acc_reg.pm1,  offs_reg.pm1,  cnt_reg, byte_in);
        acc_next.pm25 = pair_upd(acc_reg.pm25, offs_reg.pm25, cnt_reg, byte_in);
        acc_next.pm10 = pair_upd(acc_reg.pm10, offs_reg.pm10, cnt_reg, byte_in);
        acc_next.rsum = pair_upd(acc_reg.rsum, offs_reg.csum, cnt_reg, byte_in);
        if (CMP_W'(cnt_reg) < CMP_W'(offs_reg.csum))
        begin
            acc_next.csum = acc_reg.csum + {8'd0, byte_in};
        end
    end

    assign res.acc = acc_next;
    assign res.ok  = (acc_next.csum == acc_next.rsum);

    // scan control
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (step)
        begin
            busy_next = !last;
            cnt_next  = cnt_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // hold offsets for the whole scan; clear sums at its start
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            offs_reg <= offs;
            acc_reg  <= '0;
        end
        else if (step)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ----- src/particle_sensor_frame_parser_top.sv -----
// Top level: particle sensor serial frame parser
//
//   port group        dir   handshake           content
//   s_*  (rx bytes)   in    s_tvalid/s_tready   s_tdata[7:0] = rx_byte
//   m_*  (readings)   out   m_tvalid/m_tready   m_tdata = pm1, pm25, pm10, sums; m_tuser = ok
//   cfg_* (registers) in    cfg_we              cfg_addr index, cfg_wdata value
//
// One received byte is taken every cycle unless the input stalls as described below.
// Frame bytes shift into a row of FRAME_LENGTH cells; the closing byte snapshots the row,
// which then streams into the tally one byte a cycle; the result word is registered on its last byte.
// Reset restores register defaults and hunting state; no memory clearing is needed.
// The scan holds on its last byte while the output word is stalled; input stalls only
// when a closing byte arrives while the previous frame's scan is still held.
`timescale 1ns / 1ps

`include "particle_sensor_frame_parser_top_defines.svh"

module particle_sensor_frame_parser_top
    import psfp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [79:0]           m_tdata,   // pm1_value, pm25_value, pm10_value,
                                             // computed_sum, received_sum (16 bits each)
    output logic                  m_tuser,   // [0] checksum_ok
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [2:0] {
        ST_HUNT  = 3'b001,
        ST_CHECK = 3'b010,
        ST_FILL  = 3'b100
    } psfp_state_t;

    psfp_state_t      state_reg;
    psfp_state_t      state_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    logic [7:0]  first_start_reg;
    logic [7:0]  second_start_reg;
    psfp_offs_t  offs_reg;

    logic            accept;
    logic            closing;
    logic            cap_shift;
    logic            eval_load;
    logic            busy;
    logic            last;
    logic            step;
    logic            out_free;
    psfp_cell_ctrl_t cell_ctrl;
    psfp_result_t    res;

    logic         m_tvalid_reg;
    logic         m_tvalid_next;
    psfp_result_t out_reg;

    logic [7:0] cap_chain  [0:FRAME_LENGTH];
    logic [7:0] eval_chain [0:FRAME_LENGTH];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_start_reg  <= RST_FIRST_START;
            second_start_reg <= RST_SECOND_START;
            offs_reg.pm1     <= RST_PM1_OFF;
            offs_reg.pm25    <= RST_PM25_OFF;
            offs_reg.pm10    <= RST_PM10_OFF;
            offs_reg.csum    <= RST_CSUM_OFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_FIRST_START:  first_start_reg  <= cfg_wdata;
                REG_SECOND_START: second_start_reg <= cfg_wdata;
                REG_PM1_OFF:      offs_reg.pm1     <= cfg_wdata[OFF_W-1:0];
                REG_PM25_OFF:     offs_reg.pm25    <= cfg_wdata[OFF_W-1:0];
                REG_PM10_OFF:     offs_reg.pm10    <= cfg_wdata[OFF_W-1:0];
                REG_CSUM_OFF:     offs_reg.csum    <= cfg_wdata[OFF_W-1:0];
                default:          ;
            endcase
        end
    end

    // scan and output handshake
    assign out_free = !m_tvalid_reg || m_tready;
    assign step     = busy && (!last || out_free);
    assign closing  = (state_reg == ST_FILL) && (pos_reg == POS_W'(FRAME_LENGTH - 1));
    assign s_tready = !(closing && busy) || (step && last);
    assign accept   = s_tvalid && s_tready;

    // hunt for the start pair, then count the frame bytes
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        cap_shift  = 1'b0;
        eval_load  = 1'b0;
        if (accept)
        begin
            unique case (state_reg)
                ST_HUNT:
                begin
                    if (s_tdata == first_start_reg)
                    begin
                        cap_shift  = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (s_tdata == second_start_reg)
                    begin
                        cap_shift  = 1'b1;
                        pos_next   = POS_W'(2);
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
                ST_FILL:
                begin
                    cap_shift = 1'b1;
                    if (closing)
                    begin
                        eval_load  = 1'b1;
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
                default:
                begin
                    state_next = ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // row of byte cells: capture shifts in from s_tdata, scan drains towards the tally
    assign cell_ctrl.cap_shift  = cap_shift;
    assign cell_ctrl.eval_load  = eval_load;
    assign cell_ctrl.eval_shift = step;
    assign cap_chain[0]         = s_tdata;
    assign eval_chain[0]        = 8'd0;

    for (genvar i = 0; i < FRAME_LENGTH; i++)
    begin : g_cell
        psfp_cell u_cell (
            .clk     (clk),
            .ctrl    (cell_ctrl),
            .cap_in  (cap_chain[i]),
            .eval_in (eval_chain[i]),
            .cap_q   (cap_chain[i+1]),
            .eval_q  (eval_chain[i+1])
        );
    end

    psfp_tally u_tally (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (eval_load),
        .step    (step),
        .offs    (offs_reg),
        .byte_in (eval_chain[FRAME_LENGTH]),
        .busy    (busy),
        .last    (last),
        .res     (res)
    );

    // output word register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (step && last)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && last)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.acc.rsum, out_reg.acc.csum, out_reg.acc.pm10,
                       out_reg.acc.pm25, out_reg.acc.pm1};
    assign m_tuser  = out_reg.ok;

    // checks
    `PSFP_ASSERT_IMP(a_load_idle, eval_load, !busy || (step && last), "snapshot over a running scan")
    `PSFP_ASSERT_IMP(a_ok_flag, m_tvalid, m_tuser == (m_tdata[63:48] == m_tdata[79:64]), "checksum flag mismatch")
    `PSFP_ASSERT_NXT(a_hold_last, busy && last && m_tvalid && !m_tready, busy && last, "scan lost while output stalled")
    `PSFP_ASSERT_NXT(a_close_scan, accept && closing, busy, "closing word did not start a scan")

endmodule

// ----- tb/sv/tb_particle_sensor_frame_parser_top.sv -----
// Testbench for the particle sensor frame parser: byte stimulus, reading prediction and checks
`timescale 1ns / 1ps

import psfp_pkg::*;

// one expected or observed reading word
typedef struct {
    logic [15:0] pm1;
    logic [15:0] pm25;
    logic [15:0] pm10;
    logic [15:0] computed;
    logic [15:0] received;
    logic        ok;
} reading_t;

// Tracks the parser state byte by byte and holds the readings still owed by the block
class psfp_reading_checker;
    logic [7:0]       first_start;
    logic [7:0]       second_start;
    logic [OFF_W-1:0] pm1_off;
    logic [OFF_W-1:0] pm25_off;
    logic [OFF_W-1:0] pm10_off;
    logic [OFF_W-1:0] csum_off;

    bit               in_frame;
    int unsigned      position;
    logic [7:0]       frame_bytes [FRAME_LENGTH];

    reading_t         pending_readings [$];
    int               errors;
    int               readings_seen;

    function new();
        first_start   = RST_FIRST_START;
        second_start  = RST_SECOND_START;
        pm1_off       = RST_PM1_OFF;
        pm25_off      = RST_PM25_OFF;
        pm10_off      = RST_PM10_OFF;
        csum_off      = RST_CSUM_OFF;
        in_frame      = 1'b0;
        position      = 0;
        errors        = 0;
        readings_seen = 0;
        foreach (frame_bytes[i])
        begin
            frame_bytes[i] = 8'h00;
        end
    endfunction

    // mirror a register write; unknown indexes are dropped
    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_FIRST_START:  first_start  = val;
            REG_SECOND_START: second_start = val;
            REG_PM1_OFF:      pm1_off      = val[OFF_W-1:0];
            REG_PM25_OFF:     pm25_off     = val[OFF_W-1:0];
            REG_PM10_OFF:     pm10_off     = val[OFF_W-1:0];
            REG_CSUM_OFF:     csum_off     = val[OFF_W-1:0];
            default:          ;
        endcase
    endfunction

    // big-endian pair; positions past the frame read as zero
    function logic [15:0] pair_at(int unsigned pos);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = (pos < FRAME_LENGTH) ? frame_bytes[pos] : 8'h00;
        lo = (pos + 1 < FRAME_LENGTH) ? frame_bytes[pos + 1] : 8'h00;
        return {hi, lo};
    endfunction

    // advance the frame hunt by one accepted byte
    function void take_byte(logic [7:0] b);
        reading_t    r;
        logic [15:0] sum;
        if (!in_frame)
        begin
            if (b == first_start)
            begin
                frame_bytes[0] = b;
                in_frame       = 1'b1;
                position       = 1;
            end
            return;
        end
        // wrong second byte: drop the frame and the byte itself
        if (position == 1 && b != second_start)
        begin
            in_frame = 1'b0;
            position = 0;
            return;
        end
        frame_bytes[position] = b;
        position++;
        if (position < FRAME_LENGTH)
            return;

        sum = 16'h0000;
        for (int i = 0; i < csum_off && i < FRAME_LENGTH; i++)
            sum += 16'(frame_bytes[i]);
        r.pm1      = pair_at(pm1_off);
        r.pm25     = pair_at(pm25_off);
        r.pm10     = pair_at(pm10_off);
        r.computed = sum;
        r.received = pair_at(csum_off);
        r.ok       = (sum == r.received);
        pending_readings.push_back(r);
        in_frame = 1'b0;
        position = 0;
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%h, got 0x%h", field, want, got);
            errors++;
        end
    endfunction

    // match an output word against the oldest owed reading
    function void check_reading(logic [79:0] data, logic flag);
        reading_t want;
        if (pending_readings.size() == 0)
        begin
            $error("reading word 0x%h arrived with none owed", data);
            errors++;
            return;
        end
        want = pending_readings.pop_front();
        readings_seen++;
        compare_field("pm1_value",    want.pm1,      data[15:0]);
        compare_field("pm25_value",   want.pm25,     data[31:16]);
        compare_field("pm10_value",   want.pm10,     data[47:32]);
        compare_field("computed_sum", want.computed, data[63:48]);
        compare_field("received_sum", want.received, data[79:64]);
        compare_field("checksum_ok",  16'(want.ok),  16'(flag));
    endfunction
endclass

module tb_particle_sensor_frame_parser_top;

    // indexes past the register map, written to show they are ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

    localparam int SCAN_CYCLES     = FRAME_LENGTH + 8;
    localparam int RANDOM_BYTES    = 600;
    localparam int PHASE_BYTES     = 150;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
    typedef enum int {RX_ALWAYS, RX_HALF, RX_QUARTER, RX_SPARSE} stall_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;    // [7:0] rx_byte
    logic                  m_tvalid;
    logic                  m_tready;
    logic [79:0]           m_tdata;    // [15:0] pm1_value, [31:16] pm25_value, [47:32] pm10_value,
                                       // [63:48] computed_sum, [79:64] received_sum
    logic                  m_tuser;    // [0] checksum_ok
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    psfp_reading_checker   readings;
    logic [7:0]            frame_buf [FRAME_LENGTH];
    int                    bytes_sent  = 0;
    int                    burst_left  = 0;
    int                    ready_left  = 0;
    stall_mode_t           ready_mode  = RX_ALWAYS;

    particle_sensor_frame_parser_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // receiver: switch between stall patterns after runs of random length
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = stall_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(20, 300);
        end
        else
        begin
            ready_left--;
        end
        case (ready_mode)
            RX_ALWAYS:  m_tready <= 1'b1;
            RX_HALF:    m_tready <= 1'($urandom_range(0, 1));
            RX_QUARTER: m_tready <= ($urandom_range(0, 3) == 0);
            default:    m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // sample the output between edges, where nothing moves
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            readings.check_reading(m_tdata, m_tuser);
    end

    // send one byte, opening a random gap whenever a burst runs out
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        readings.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_span(input int first, input int last);
        for (int i = first; i <= last; i++)
            send_byte(frame_buf[i]);
    endtask

    // hold the input until every owed reading is out and the scan has settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (readings.pending_readings.size() != 0)
            @(posedge clk);
        repeat (SCAN_CYCLES) @(posedge clk);
    endtask

    // leaves the write enable high so back-to-back writes need no toggle
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        readings.write_reg(idx, val);
    endtask

    task automatic load_config(input logic [7:0] first, input logic [7:0] second,
                               input logic [7:0] p1, input logic [7:0] p25,
                               input logic [7:0] p10, input logic [7:0] cs);
        cfg_write(REG_FIRST_START, first);
        cfg_write(REG_SECOND_START, second);
        cfg_write(REG_PM1_OFF, p1);
        cfg_write(REG_PM25_OFF, p25);
        cfg_write(REG_PM10_OFF, p10);
        cfg_write(REG_CSUM_OFF, cs);
        cfg_we <= 1'b0;
    endtask

    // build a frame for the current start bytes; optionally plant a matching checksum
    function automatic void make_frame(fill_t fill, bit good_sum);
        logic [15:0] sum;
        int          off;
        off          = readings.csum_off;
        frame_buf[0] = readings.first_start;
        frame_buf[1] = readings.second_start;
        for (int i = 2; i < FRAME_LENGTH; i++)
        begin
            case (fill)
                FILL_ZERO: frame_buf[i] = 8'h00;
                FILL_ONES: frame_buf[i] = 8'hFF;
                default:   frame_buf[i] = 8'($urandom);
            endcase
        end
        if (good_sum && off >= 2)
        begin
            sum = 16'h0000;
            for (int i = 0; i < off; i++)
                sum += 16'(frame_buf[i]);
            frame_buf[off]     = sum[15:8];
            frame_buf[off + 1] = sum[7:0];
        end
    endfunction

    // mostly whole frames with random payload, the rest noise, bad openings and cut frames
    task automatic random_phase(input int n_bytes);
        int         stop_at;
        int         pick;
        logic [7:0] b;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                make_frame(FILL_RANDOM, $urandom_range(0, 3) != 0);
                send_span(0, FRAME_LENGTH - 1);
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 8))
                    send_byte(($urandom_range(0, 4) == 0) ? readings.first_start : 8'($urandom));
            end
            else if (pick < 95)
            begin
                b = ($urandom_range(0, 2) == 0) ? readings.first_start
                                                : readings.second_start ^ 8'($urandom_range(1, 255));
                send_byte(readings.first_start);
                send_byte(b);
            end
            else
            begin
                make_frame(FILL_RANDOM, 1'b1);
                send_span(0, $urandom_range(1, FRAME_LENGTH - 2));
            end
        end
    endtask

    initial
    begin
        int base_bytes;
        readings  = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: all-ones payload with good sum, all-zero payload with bad sum
        make_frame(FILL_ONES, 1'b1);
        send_span(0, FRAME_LENGTH - 1);
        make_frame(FILL_ZERO, 1'b0);
        send_span(0, FRAME_LENGTH - 1);

        // second byte repeats the first start byte: dropped, not taken as a new opening
        send_byte(RST_FIRST_START);
        send_byte(RST_FIRST_START);
        send_byte(RST_SECOND_START);
        make_frame(FILL_RANDOM, 1'b1);
        send_span(0, FRAME_LENGTH - 1);

        // move the reading offsets while a frame is half received
        make_frame(FILL_RANDOM, 1'b1);
        send_span(0, 11);
        wait_idle();
        cfg_write(REG_PM1_OFF, 8'd10);
        cfg_write(REG_PM25_OFF, 8'd20);
        cfg_write(REG_PM10_OFF, 8'd0);
        cfg_we <= 1'b0;
        send_span(12, FRAME_LENGTH - 1);

        // change the second start byte right after the opening byte
        wait_idle();
        send_byte(RST_FIRST_START);
        wait_idle();
        cfg_write(REG_SECOND_START, 8'h4E);
        cfg_we <= 1'b0;
        make_frame(FILL_RANDOM, 1'b1);
        send_span(1, FRAME_LENGTH - 1);
        wait_idle();

        // extreme start bytes, offsets at both ends of the frame
        load_config(8'h00, 8'hFF, 8'd0, 8'd30, 8'd15, 8'd30);
        make_frame(FILL_RANDOM, 1'b1);
        send_span(0, FRAME_LENGTH - 1);
        make_frame(FILL_ONES, 1'b0);
        send_span(0, FRAME_LENGTH - 1);
        wait_idle();

        // checksum offset zero: empty sum; spare indexes must not disturb anything
        cfg_write(REG_SPARE_A, 8'hFF);
        cfg_write(REG_SPARE_B, 8'h00);
        load_config(8'hFF, 8'h00, 8'd30, 8'd0, 8'd29, 8'd0);
        make_frame(FILL_RANDOM, 1'b0);
        send_span(0, FRAME_LENGTH - 1);
        wait_idle();

        // identical start bytes, checksum straight after the opening byte
        load_config(8'hA5, 8'hA5, 8'd1, 8'd2, 8'd28, 8'd1);
        make_frame(FILL_ZERO, 1'b0);
        send_span(0, FRAME_LENGTH - 1);
        wait_idle();

        // random settings per phase until enough bytes have passed
        base_bytes = bytes_sent;
        while (bytes_sent - base_bytes < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 3) == 0)
                cfg_write(REG_SPARE_B, 8'($urandom));
            load_config(8'($urandom), 8'($urandom),
                        8'($urandom_range(0, 30)), 8'($urandom_range(0, 30)),
                        8'($urandom_range(0, 30)), 8'($urandom_range(1, 30)));
            random_phase(PHASE_BYTES);
            wait_idle();
        end

        if (readings.errors == 0 && readings.pending_readings.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
